// ----- design/go_to_goal_velocity_controller_macros.svh -----
// Assertion macros for the go-to-goal velocity controller.
// Used by the top level; no other dependencies.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define GGVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ggvc: same-cycle check failed");
`define GGVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ggvc: next-cycle check failed");
`else
`define GGVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GGVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/ggvc_pkg.sv -----
// Shared constants, widths and types for the go-to-goal velocity controller.
// No dependencies.
package ggvc_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int POSITION_WIDTH = 16;
    localparam int CORDIC_GUARD   = 8;

    localparam int N_ITER = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    // offset, CORDIC datapath and Q.16 angle widths
    localparam int DW = POSITION_WIDTH + 1;
    localparam int XW = DW + CORDIC_GUARD + 3;
    localparam int ZW = 20;
    localparam int PMW = XW + 17;
    localparam int DIST_W = PMW - 16 - CORDIC_GUARD;
    localparam int BW = ZW - 3;
    localparam int EW = BW + 1;
    localparam int LW = DIST_W + 17;
    localparam int TW = EW + 17;

    localparam int CFG_W = (POSITION_WIDTH > 16) ? POSITION_WIDTH : 16;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_GOAL_X     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GOAL_Y     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ARRIVE_TOL = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPEED_GAIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_TURN_GAIN  = 3'd4;

    localparam logic [14:0] TOL_RESET        = 15'd154;
    localparam logic [15:0] SPEED_GAIN_RESET = 16'd819;
    localparam logic [15:0] TURN_GAIN_RESET  = 16'd2048;

    localparam logic [15:0] INV_GAIN = 16'd39797;
    localparam logic signed [ZW-1:0] HALF_PI = 20'sd102944;

    localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2,
        20'sd1,     20'sd0,     20'sd0,     20'sd0,
        20'sd0,     20'sd0,     20'sd0,     20'sd0
    };

    // pipeline stage positions
    localparam int NST     = N_ITER + 5;
    localparam int ST_GAIN = N_ITER + 2;
    localparam int ST_MUL  = N_ITER + 3;
    localparam int ST_OUT  = N_ITER + 4;

    typedef struct packed {
        logic signed [15:0] head;
        logic               zero;
    } t_side;

endpackage

// ----- design/ggvc_cordic.sv -----
// Pipelined CORDIC vectoring unit: quadrant pre-rotation stage plus one
// register stage per iteration. Depends on ggvc_pkg.
module ggvc_cordic import ggvc_pkg::*; (
    input  logic                 i_clk,
    input  logic [N_ITER:0]      i_en,
    input  logic signed [DW-1:0] i_dx,
    input  logic signed [DW-1:0] i_dy,
    input  t_side                i_side,
    output logic signed [XW-1:0] o_mag,
    output logic signed [ZW-1:0] o_ang,
    output t_side                o_side
);

    logic signed [XW-1:0] r_x    [N_ITER+1];
    logic signed [XW-1:0] r_y    [N_ITER+1];
    logic signed [ZW-1:0] r_z    [N_ITER+1];
    t_side                r_side [N_ITER+1];

    logic signed [XW-1:0] x0, y0;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    assign x0 = XW'(i_dx) <<< CORDIC_GUARD;
    assign y0 = XW'(i_dy) <<< CORDIC_GUARD;

    always_comb begin
        n_x = x0;
        n_y = y0;
        n_z = '0;
        if (x0[XW-1]) begin
            if (!y0[XW-1]) begin
                n_x = y0;
                n_y = -x0;
                n_z = HALF_PI;
            end else begin
                n_x = -y0;
                n_y = x0;
                n_z = -HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N_ITER; k++) begin : g_iter
        logic signed [XW-1:0] xs, ys;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en[k+1]) begin
                if (!r_y[k][XW-1]) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + ATAN_TAB[k];
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - ATAN_TAB[k];
                end
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_mag  = r_x[N_ITER];
    assign o_ang  = r_z[N_ITER];
    assign o_side = r_side[N_ITER];

endmodule

// ----- design/go_to_goal_velocity_controller.sv -----
// Go-to-goal proportional velocity controller, top level.
// Depends on ggvc_pkg, ggvc_cordic and the assertion macro header.
//
// Accepts one pose sample per clock unless stalled and returns one speed
// command per pose, in order, through an offset stage, a quadrant
// pre-rotation stage, one stage per CORDIC iteration, a gain/bearing stage,
// a multiply stage and the output register. Throughput is one pose per
// cycle while the output is not stalled. Each stage holds its request
// only while every stage downstream is full, so bubbles close up under an
// output stall and the input stalls only when the whole pipeline is full.
// Goal and gain registers are read as requests pass; write them while idle.
module go_to_goal_velocity_controller import ggvc_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [IDX_W-1:0]                 i_cfg_index,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [POSITION_WIDTH-1:0] i_pos_x,
    input  logic signed [POSITION_WIDTH-1:0] i_pos_y,
    input  logic signed [15:0]               i_heading,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [14:0]                      o_linear_speed,
    output logic signed [15:0]               o_turn_rate,
    output logic                             o_arrived
);

`include "go_to_goal_velocity_controller_macros.svh"

    logic signed [POSITION_WIDTH-1:0] r_goal_x, r_goal_y;
    logic [14:0]                      r_tol;
    logic [15:0]                      r_speed_gain, r_turn_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_tol        <= TOL_RESET;
            r_speed_gain <= SPEED_GAIN_RESET;
            r_turn_gain  <= TURN_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GOAL_X:     r_goal_x     <= i_cfg_data[POSITION_WIDTH-1:0];
                REG_GOAL_Y:     r_goal_y     <= i_cfg_data[POSITION_WIDTH-1:0];
                REG_ARRIVE_TOL: r_tol        <= i_cfg_data[14:0];
                REG_SPEED_GAIN: r_speed_gain <= i_cfg_data[15:0];
                REG_TURN_GAIN:  r_turn_gain  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage enables and valid bits
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign en[k] = !i_stall || !(&r_vld[NST-1:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NST-1];

    // offset to goal
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [15:0]   r_head;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx   <= DW'(r_goal_x) - DW'(i_pos_x);
            r_dy   <= DW'(r_goal_y) - DW'(i_pos_y);
            r_head <= i_heading;
        end
    end

    t_side                c_side_in, c_side_out;
    logic signed [XW-1:0] c_mag;
    logic signed [ZW-1:0] c_ang;

    assign c_side_in.head = r_head;
    assign c_side_in.zero = (r_dx == '0) && (r_dy == '0);

    ggvc_cordic u_cordic (
        .i_clk  (i_clk),
        .i_en   (en[N_ITER+1:1]),
        .i_dx   (r_dx),
        .i_dy   (r_dy),
        .i_side (c_side_in),
        .o_mag  (c_mag),
        .o_ang  (c_ang),
        .o_side (c_side_out)
    );

    // gain correction product and heading error
    logic signed [ZW:0]    bsum;
    logic signed [BW-1:0]  bearing;
    logic signed [PMW-1:0] r_pmag;
    logic signed [EW-1:0]  r_err;

    assign bsum    = (ZW+1)'(c_ang) + (ZW+1)'(8);
    assign bearing = c_side_out.zero ? '0 : BW'(bsum >>> 4);

    always_ff @(posedge i_clk) begin
        if (en[ST_GAIN]) begin
            r_pmag <= PMW'(c_mag) * PMW'($signed({1'b0, INV_GAIN}));
            r_err  <= EW'(bearing) - EW'(c_side_out.head);
        end
    end

    // distance, arrival test and command products
    logic signed [PMW-1:0]    dsum;
    logic signed [DIST_W-1:0] distance;
    logic signed [LW-1:0]     r_plin;
    logic signed [TW-1:0]     r_pturn;
    logic                     r_arr;

    assign dsum     = r_pmag + PMW'(1 << (15 + CORDIC_GUARD));
    assign distance = DIST_W'(dsum >>> (16 + CORDIC_GUARD));

    always_ff @(posedge i_clk) begin
        if (en[ST_MUL]) begin
            r_arr   <= distance < DIST_W'($signed({1'b0, r_tol}));
            r_plin  <= LW'(distance) * LW'($signed({1'b0, r_speed_gain}));
            r_pturn <= TW'(r_err) * TW'($signed({1'b0, r_turn_gain}));
        end
    end

    // rounding, saturation and output register
    logic signed [LW-1:0] lsh;
    logic signed [TW-1:0] tsh;
    logic [14:0]          n_lin;
    logic signed [15:0]   n_turn;
    logic [14:0]          r_lin;
    logic signed [15:0]   r_turn;
    logic                 r_arr_out;

    assign lsh = (r_plin + LW'(2048)) >>> 12;
    assign tsh = (r_pturn + TW'(2048)) >>> 12;

    always_comb begin
        if (r_arr) begin
            n_lin  = '0;
            n_turn = '0;
        end else begin
            if (lsh > LW'(32767)) begin
                n_lin = 15'h7FFF;
            end else begin
                n_lin = lsh[14:0];
            end
            priority if (tsh > TW'(32767)) begin
                n_turn = 16'sh7FFF;
            end else if (tsh < -TW'(32768)) begin
                n_turn = -16'sh8000;
            end else begin
                n_turn = tsh[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_lin     <= n_lin;
            r_turn    <= n_turn;
            r_arr_out <= r_arr;
        end
    end

    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;
    assign o_arrived      = r_arr_out;

    `GGVC_ASSERT_IMPLY(a_arrived_zero, i_clk, i_rst_n, o_valid && o_arrived, (o_linear_speed == '0) && (o_turn_rate == '0))
    `GGVC_ASSERT_IMPLY(a_stall_only_full, i_clk, i_rst_n, o_stall, &r_vld)
    `GGVC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for go_to_goal_velocity_controller: directed pose table, then
// random phases with new goals and gains, random idling and long output stalls.
// Depends on ggvc_pkg and block RTL; an internal CORDIC predictor or the table checks results.
module testbench;
    import ggvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STAGES          = N_ITER;
    localparam int    LATENCY         = STAGES + 5;
    localparam int    CYCLE_LIMIT     = 200000;
    localparam int    LONG_HOLD       = 80;
    localparam int    RANDOM_PHASES   = 7;
    localparam int    POSES_PER_PHASE = 100;
    localparam int    N_CASES         = 23;
    localparam longint GUARD_SCALE    = 256;
    localparam longint INV_GAIN_Q16   = 39797;
    localparam longint HALF_PI_Q16    = 102944;
    localparam longint ATAN_Q16 [24] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    localparam logic [IDX_W-1:0] REG_UNUSED_LO = REG_TURN_GAIN + 1'b1;
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic [14:0]        lin;
        logic signed [15:0] turn;
        logic               arr;
    } t_cmd;

    typedef struct packed {
        logic               recfg;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic [15:0]        tol;
        logic [15:0]        sg;
        logic [15:0]        tg;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] hd;
        logic               known;
        t_cmd               want;
    } t_pose_case;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [IDX_W-1:0]                 i_cfg_index;
    logic [CFG_W-1:0]                 i_cfg_data;
    logic                             i_valid;
    logic                             o_stall;
    logic signed [POSITION_WIDTH-1:0] i_pos_x;
    logic signed [POSITION_WIDTH-1:0] i_pos_y;
    logic signed [15:0]               i_heading;
    logic                             o_valid;
    logic                             i_stall;
    logic [14:0]                      o_linear_speed;
    logic signed [15:0]               o_turn_rate;
    logic                             o_arrived;

    // predictor copy of the goal and gain registers
    logic signed [15:0] goal_x_r      = '0;
    logic signed [15:0] goal_y_r      = '0;
    logic [14:0]        tol_r         = 15'd154;
    logic [15:0]        speed_gain_r  = 16'd819;
    logic [15:0]        turn_gain_r   = 16'd2048;

    t_cmd pending_cmds [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    bit   steady         = 1'b0;
    bit   hold_outputs   = 1'b0;

    t_pose_case pose_cases [N_CASES] = '{
        '{0, 0, 0, 0, 0, 0,           0,      0,      0, 1, '{0, 0, 1}},
        '{0, 0, 0, 0, 0, 0,           0,      0, -32768, 1, '{0, 0, 1}},
        '{0, 0, 0, 0, 0, 0,      -32768, -32768, -32768, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,       32767,  32767,  32767, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,       32767, -32768,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,      -32768,  32767,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,         100,      0,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,           0,   -100,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,           0,    100,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,        -154,      0,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,        -153,      0,      0, 0, '{0, 0, 0}},
        // zero tolerance, full gains: at the goal nothing is arrived
        '{1, 32767, -32768, 0, 65535, 65535,
                                  32767, -32768,      0, 1, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,      -32768,  32767, -32768, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,      -32768,  32767,  32767, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,       32767, -32767,      0, 0, '{0, 0, 0}},
        // tolerance written with bit 15 set, zero gains
        '{1, -32768, 32767, 65535, 0, 0,
                                  32767, -32768,   5000, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,      -32768,  32767,      0, 1, '{0, 0, 1}},
        '{0, 0, 0, 0, 0, 0,           0,      0,      0, 0, '{0, 0, 0}},
        '{1, -1, 1, 1, 4096, 4096,    0,      0,      0, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,          -1,      1,      0, 1, '{0, 0, 1}},
        '{0, 0, 0, 0, 0, 0,          -1,      0,  12868, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,          -2,      1, -12868, 0, '{0, 0, 0}},
        '{0, 0, 0, 0, 0, 0,          -1,      1,  32767, 1, '{0, 0, 1}}
    };

    go_to_goal_velocity_controller u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_heading      (i_heading),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate),
        .o_arrived      (o_arrived)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_cmds.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_cmd predict_command(input logic signed [15:0] px,
                                             input logic signed [15:0] py,
                                             input logic signed [15:0] hd);
        longint dx, dy, xc, yc, zc, t, xs, ys, distance, bearing, lin, turn;
        t_cmd   c;
        dx = longint'(goal_x_r) - longint'(px);
        dy = longint'(goal_y_r) - longint'(py);
        xc = dx * GUARD_SCALE;
        yc = dy * GUARD_SCALE;
        zc = 0;
        // left half plane: rotate by a quarter turn first
        if (xc < 0) begin
            t = xc;
            if (yc >= 0) begin
                xc = yc;
                yc = -t;
                zc = HALF_PI_Q16;
            end else begin
                xc = -yc;
                yc = t;
                zc = -HALF_PI_Q16;
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = xc >>> i;
            ys = yc >>> i;
            if (yc >= 0) begin
                xc = xc + ys;
                yc = yc - xs;
                zc = zc + ATAN_Q16[i];
            end else begin
                xc = xc - ys;
                yc = yc + xs;
                zc = zc - ATAN_Q16[i];
            end
        end
        distance = (xc * INV_GAIN_Q16 + (longint'(1) << 23)) >>> 24;
        bearing  = (dx == 0 && dy == 0) ? 0 : ((zc + 8) >>> 4);
        if (distance < longint'(tol_r)) begin
            c = '{lin: '0, turn: '0, arr: 1'b1};
        end else begin
            lin = (distance * longint'(speed_gain_r) + 2048) >>> 12;
            if (lin > 32767) lin = 32767;
            turn = ((bearing - longint'(hd)) * longint'(turn_gain_r) + 2048) >>> 12;
            if (turn > 32767) turn = 32767;
            if (turn < -32768) turn = -32768;
            c.lin  = lin[14:0];
            c.turn = turn[15:0];
            c.arr  = 1'b0;
        end
        return c;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // caller lowers i_cfg_we after the last write of a burst
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_GOAL_X:     goal_x_r     = data;
            REG_GOAL_Y:     goal_y_r     = data;
            REG_ARRIVE_TOL: tol_r        = data[14:0];
            REG_SPEED_GAIN: speed_gain_r = data;
            REG_TURN_GAIN:  turn_gain_r  = data;
            default: ;
        endcase
    endtask

    task automatic load_controller_regs(input logic [15:0] gx, input logic [15:0] gy,
                                        input logic [15:0] tol, input logic [15:0] sg,
                                        input logic [15:0] tg);
        logic [IDX_W-1:0] junk_idx;
        junk_idx = IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI));
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        write_reg(REG_ARRIVE_TOL, tol);
        write_reg(REG_SPEED_GAIN, sg);
        write_reg(REG_TURN_GAIN, tg);
        write_reg(junk_idx, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_commands();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_cmds.size() != 0);
    endtask

    task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic signed [15:0] hd, input logic known,
                             input t_cmd want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pos_x   <= px;
        i_pos_y   <= py;
        i_heading <= hd;
        do @(posedge i_clk); while (o_stall);
        pending_cmds.push_back(known ? want : predict_command(px, py, hd));
    endtask

    function automatic logic [15:0] pick_position();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 16'($urandom_range(0, 8192));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_tolerance();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 400));
            default: return 16'($urandom);
        endcase
    endfunction

    // result side
    initial begin
        int   hold;
        t_cmd want;
        i_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_outputs) begin
                hold_outputs = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = steady ? 0 : $urandom_range(0, 3);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            if (pending_cmds.size() == 0) begin
                flag_mismatch("result with no request pending", 1, 0);
            end else begin
                want = pending_cmds.pop_front();
                if (o_linear_speed !== want.lin)
                    flag_mismatch("linear_speed", o_linear_speed, want.lin);
                if (o_turn_rate !== want.turn)
                    flag_mismatch("turn_rate", o_turn_rate, want.turn);
                if (o_arrived !== want.arr)
                    flag_mismatch("arrived", o_arrived, want.arr);
            end
        end
    end

    // request side
    initial begin
        logic signed [15:0] gx, gy, px, py, hd;
        logic [15:0]        tol, sg, tg;
        int                 kind;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_heading   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pose_cases[r]) begin
            if (pose_cases[r].recfg) begin
                drain_commands();
                load_controller_regs(pose_cases[r].gx, pose_cases[r].gy, pose_cases[r].tol,
                                     pose_cases[r].sg, pose_cases[r].tg);
            end
            send_pose(pose_cases[r].px, pose_cases[r].py, pose_cases[r].hd,
                      pose_cases[r].known, pose_cases[r].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_commands();
            if (p == 0) begin
                gx = 16'sh7FFF; gy = 16'sh7FFF; tol = 16'h7FFF; sg = '1; tg = '1;
            end else if (p == 1) begin
                gx = 16'sh8000; gy = 16'sh8000; tol = '0; sg = '0; tg = '0;
            end else begin
                gx = pick_position(); gy = pick_position();
                tol = pick_tolerance(); sg = pick_gain(); tg = pick_gain();
            end
            load_controller_regs(gx, gy, tol, sg, tg);
            steady = (p % 3 == 1);
            for (int k = 0; k < POSES_PER_PHASE; k++) begin
                if (p == 2 && k == 10) hold_outputs = 1'b1;
                if (p == 3 && k == 50) drain_commands();
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    px = gx + 16'($urandom_range(0, 800)) - 16'sd400;
                    py = gy + 16'($urandom_range(0, 800)) - 16'sd400;
                end else if (kind == 8) begin
                    px = pick_position();
                    py = pick_position();
                end else if (kind == 9) begin
                    px = gx;
                    py = gy;
                end else begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                hd = $urandom_range(0, 1) ? 16'($urandom) : pick_position();
                send_pose(px, py, hd, 1'b0, '0);
            end
        end

        drain_commands();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- go_to_goal_velocity_controller.f -----
+incdir+design
design/ggvc_pkg.sv
design/ggvc_cordic.sv
design/go_to_goal_velocity_controller.sv
tb/testbench.sv
